// File: hdl/dlq_pkg.sv
// Shared types, field widths and command/status codes for the delay queue.
package dlq_pkg;

	// Fixed field widths of the two channels and the register.
	localparam int CMD_W    = 2;
	localparam int HANDLE_W = 16;
	localparam int ADDR_W   = 48;
	localparam int STATUS_W = 3;
	localparam int LEVEL_W  = 7;
	localparam int STAMP_W  = 32;
	localparam int LAT_W    = 16;

	// Defaults for the top-level parameters.
	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_HANDLE_BITS = 16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_TICK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd4;

	// Input beat.
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] message_handle;
		logic [ADDR_W-1:0]   peer_address;
	} in_t;

	// Output beat.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] ready_handle;
		logic [ADDR_W-1:0]   ready_address;
		logic [LEVEL_W-1:0]  queue_level;
	} out_t;

endpackage

// File: hdl/dlq_mem.sv
// Entry store: one write port and one read port with registered read data.
module dlq_mem import dlq_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH,
	parameter int WIDTH = HANDLE_W + ADDR_W + STAMP_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/fixed_latency_delay_queue.sv
// Any beat but a poll of a non-empty queue has its result registered on acceptance; such a
// poll passes the pending-poll flag and the store's read register first.
// Throughput: one tick, push or empty poll per cycle unless the output stalls; a poll of a
// non-empty queue holds the input while it reads the entry store.
// Reset clears pointers, fill count, time counter, latency register and output valid.
// The entry store is not cleared; entries are read only after a push has written them.
module fixed_latency_delay_queue import dlq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [LAT_W-1:0] cfg_wdata
);

	localparam int PtrW    = $clog2(QUEUE_DEPTH);
	localparam int CntW    = $clog2(QUEUE_DEPTH + 1);
	localparam int StoreHW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int WordW   = StoreHW + ADDR_W + STAMP_W;

	logic [PtrW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [CntW-1:0]    fill_q, fill_d;
	logic [STAMP_W-1:0] now_q, now_d;
	logic [LAT_W-1:0]   lat_q;
	logic               poll_s1, poll_d;
	logic               out_valid_q;
	out_t               out_q, out_d;
	logic               out_load;

	logic               accept, full, empty;
	logic               mem_we, mem_re;
	logic [WordW-1:0]   wword, rword;
	logic [StoreHW-1:0] rd_handle;
	logic [ADDR_W-1:0]  rd_addr;
	logic [STAMP_W-1:0] rd_stamp, elapsed;
	logic               head_ready;
	logic [PtrW-1:0]    head_inc, tail_inc;
	logic [CntW-1:0]    fill_inc, fill_dec;

	dlq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(WordW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (wword),
		.re    (mem_re),
		.raddr (head_q),
		.rdata (rword)
	);

	// Handshake: new beats wait while a poll reads the store or the output is stuck.
	assign in_ready  = !poll_s1 && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full  = (fill_q == CntW'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);

	// Wrapping pointer and count arithmetic.
	assign head_inc = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign fill_inc = fill_q + 1'b1;
	assign fill_dec = fill_q - 1'b1;

	// Store port controls and word packing.
	assign mem_we = accept && (in_data.cmd == CMD_PUSH) && !full;
	assign mem_re = accept && (in_data.cmd == CMD_POLL) && !empty;
	assign wword  = {now_q, in_data.peer_address, in_data.message_handle[StoreHW-1:0]};
	assign {rd_stamp, rd_addr, rd_handle} = rword;

	// Age of the head entry against the latency, modulo the counter width.
	assign elapsed    = now_q - rd_stamp;
	assign head_ready = (lat_q == '0) || (elapsed >= STAMP_W'(lat_q));

	// Next state and output beat.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		now_d    = now_q;
		poll_d   = 1'b0;
		out_load = 1'b0;
		out_d    = '0;
		out_d.queue_level = LEVEL_W'({{LEVEL_W{1'b0}}, fill_q});
		if (poll_s1) begin
			out_load = 1'b1;
			if (head_ready) begin
				head_d = head_inc;
				fill_d = fill_dec;
				out_d.status        = ST_DELIVERED;
				out_d.ready_handle  = HANDLE_W'({{HANDLE_W{1'b0}}, rd_handle});
				out_d.ready_address = rd_addr;
				out_d.queue_level   = LEVEL_W'({{LEVEL_W{1'b0}}, fill_dec});
			end else begin
				out_d.status = ST_NONE;
			end
		end else if (accept) begin
			case (in_data.cmd)
				CMD_TICK: begin
					now_d        = now_q + 1'b1;
					out_load     = 1'b1;
					out_d.status = ST_TICK;
				end
				CMD_PUSH: begin
					out_load = 1'b1;
					if (full) begin
						out_d.status = ST_DROPPED;
					end else begin
						tail_d            = tail_inc;
						fill_d            = fill_inc;
						out_d.status      = ST_PUSHED;
						out_d.queue_level = LEVEL_W'({{LEVEL_W{1'b0}}, fill_inc});
					end
				end
				CMD_POLL: begin
					if (empty) begin
						out_load     = 1'b1;
						out_d.status = ST_NONE;
					end else begin
						poll_d = 1'b1;
					end
				end
				default: begin
					out_load     = 1'b1;
					out_d.status = ST_NONE;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			now_q       <= '0;
			lat_q       <= '0;
			poll_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			now_q   <= now_d;
			poll_s1 <= poll_d;
			if (cfg_we) begin
				lat_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

`ifndef SYNTHESIS
	// The fill count never passes the queue depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	// A pending poll never stays pending into the next cycle.
	a_poll_once: assert property (@(posedge clk) disable iff (!arst_n)
		poll_s1 |=> !poll_s1)
		else $error("poll pending for more than one cycle");

	// A new result never overwrites a beat that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output beat overwritten");

	// Pointers agree with the count when the queue is empty or full.
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (head_q == tail_q))
		else $error("pointers disagree with fill count");
`endif

endmodule

// File: tb/fixed_latency_delay_queue_tb.sv
// Self-checking testbench for the delay queue: directed and random beats against a predictor.
module fixed_latency_delay_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dlq_pkg::*;

	localparam int          DEPTH        = DEF_QUEUE_DEPTH;
	localparam longint      LIMIT_CYCLES = 1000000;
	// Settling time after the last expected result has come back.
	localparam int          SETTLE_CYCLES = 4;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_e;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [LAT_W-1:0] cfg_wdata = '0;

	// Predicted queue contents, time base and latency setting.
	logic [HANDLE_W-1:0] held_handle [DEPTH];
	logic [ADDR_W-1:0]   held_address [DEPTH];
	logic [STAMP_W-1:0]  held_stamp [DEPTH];
	int unsigned         head_idx = 0;
	int unsigned         tail_idx = 0;
	int unsigned         fill_level = 0;
	logic [STAMP_W-1:0]  now_count = '0;
	logic [LAT_W-1:0]    delay_ticks = '0;

	out_t   pending_results [$];
	int     error_count = 0;
	longint cycle_count = 0;

	// Sender and receiver idling controls.
	bit          tx_gaps = 1'b1;
	int unsigned burst_left = 0;
	rx_mode_e    rx_mode = RX_PATTERN;
	logic [15:0] stall_mask = 16'hA5F1;
	logic [3:0]  stall_phase = '0;

	fixed_latency_delay_queue #(
		.QUEUE_DEPTH(DEPTH),
		.HANDLE_BITS(DEF_HANDLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out the result of one accepted beat and advance the predicted state.
	function automatic out_t apply_queue_beat(in_t b);
		out_t r;
		logic [STAMP_W-1:0] age;
		r = '0;
		r.status = ST_NONE;
		case (b.cmd)
			CMD_TICK: begin
				now_count = now_count + 1'b1;
				r.status = ST_TICK;
			end
			CMD_PUSH: begin
				if (fill_level >= DEPTH) begin
					r.status = ST_DROPPED;
				end else begin
					held_handle[tail_idx] = b.message_handle;
					held_address[tail_idx] = b.peer_address;
					held_stamp[tail_idx] = now_count;
					tail_idx = (tail_idx + 1) % DEPTH;
					fill_level++;
					r.status = ST_PUSHED;
				end
			end
			CMD_POLL: begin
				if (fill_level != 0) begin
					// Elapsed time wraps with the 32-bit counter.
					age = now_count - held_stamp[head_idx];
					if (delay_ticks == '0 || age >= STAMP_W'(delay_ticks)) begin
						r.ready_handle = held_handle[head_idx];
						r.ready_address = held_address[head_idx];
						head_idx = (head_idx + 1) % DEPTH;
						fill_level--;
						r.status = ST_DELIVERED;
					end
				end
			end
			default: begin
			end
		endcase
		r.queue_level = LEVEL_W'(fill_level);
		return r;
	endfunction

	function automatic in_t make_beat(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h,
			logic [ADDR_W-1:0] a);
		in_t b;
		b.cmd = c;
		b.message_handle = h;
		b.peer_address = a;
		return b;
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] %s mismatch: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Record the expected result of every input beat taken by the block.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			pending_results.insert(pending_results.size(), apply_queue_beat(in_data));
	end

	// Compare every output beat with the oldest expected result.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat, status", out_data.status, '0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.ready_handle !== want.ready_handle)
					report_mismatch("ready_handle", out_data.ready_handle, want.ready_handle);
				if (out_data.ready_address !== want.ready_address)
					report_mismatch("ready_address", out_data.ready_address, want.ready_address);
				if (out_data.queue_level !== want.queue_level)
					report_mismatch("queue_level", out_data.queue_level, want.queue_level);
			end
		end
	end

	// Receiver back-pressure: a rotating 16-bit stall mask, reloaded each time the phase wraps.
	always @(negedge clk) begin
		if (rx_mode == RX_ALWAYS) begin
			out_ready = 1'b1;
		end else begin
			out_ready = stall_mask[stall_phase];
			stall_phase = stall_phase + 1'b1;
			if (stall_phase == '0) begin
				if ($urandom_range(0, 3) == 0)
					stall_mask = 16'hFFFF;
				else
					stall_mask = 16'($urandom) | 16'h0001;
			end
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("fixed_latency_delay_queue verification failed");
			$finish;
		end
	end

	// Present one beat and hold it until it is taken; gaps fall between bursts.
	task automatic send_beat(in_t b);
		@(negedge clk);
		if (tx_gaps) begin
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_data = b;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the latency register while the block is idle.
	task automatic set_delay(logic [LAT_W-1:0] v);
		wait_drained();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		delay_ticks = v;
	endtask

	task automatic send_tick();
		send_beat(make_beat(CMD_TICK, 16'($urandom), random_address()));
	endtask

	task automatic send_poll();
		send_beat(make_beat(CMD_POLL, 16'($urandom), random_address()));
	endtask

	task automatic send_push(logic [HANDLE_W-1:0] h, logic [ADDR_W-1:0] a);
		send_beat(make_beat(CMD_PUSH, h, a));
	endtask

	// Random beats with the given mix; halfway through the sender waits for the queue of results.
	task automatic send_random_mix(int unsigned count, int unsigned push_pct,
			int unsigned poll_pct);
		int unsigned pick;
		logic [CMD_W-1:0] c;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				c = CMD_PUSH;
			else if (pick < push_pct + poll_pct)
				c = CMD_POLL;
			else if (pick < 99)
				c = CMD_TICK;
			else
				c = CMD_UNUSED;
			send_beat(make_beat(c, 16'($urandom), random_address()));
		end
	endtask

	// Every command at reset latency, empty poll, the unused code and extreme payloads.
	task automatic test_basic_commands();
		send_poll();
		send_beat(make_beat(CMD_UNUSED, 16'hFFFF, '1));
		send_tick();
		send_push('0, '0);
		send_push(16'hFFFF, '1);
		send_poll();
		send_poll();
		send_poll();
		send_push(16'($urandom), random_address());
		send_tick();
		send_beat(make_beat(CMD_UNUSED, 16'($urandom), random_address()));
		send_poll();
	endtask

	// A head entry stays put until it has aged the set number of ticks.
	task automatic test_latency_hold();
		set_delay(16'd3);
		send_push(16'h1234, 48'h0A00_0001_1F90);
		send_poll();
		send_tick();
		send_tick();
		send_poll();
		send_push(16'hBEEF, random_address());
		send_tick();
		send_poll();
		send_poll();
		send_tick();
		send_tick();
		send_poll();
	endtask

	// Largest latency: a run of back-to-back ticks never releases the head.
	task automatic test_max_latency();
		set_delay(16'hFFFF);
		tx_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		send_push(16'($urandom), random_address());
		send_poll();
		repeat (20) send_tick();
		send_poll();
		send_tick();
		send_poll();
		wait_drained();
		tx_gaps = 1'b1;
		rx_mode = RX_PATTERN;
	endtask

	// Zero latency: every poll of a non-empty queue releases the head entry.
	task automatic test_zero_latency_traffic();
		set_delay('0);
		send_random_mix(230, 50, 40);
	endtask

	// Push-heavy traffic fills the queue and drops; poll-heavy traffic drains it.
	task automatic test_full_queue();
		set_delay('0);
		tx_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		send_random_mix(130, 80, 10);
		tx_gaps = 1'b1;
		rx_mode = RX_PATTERN;
		send_random_mix(90, 10, 80);
	endtask

	// Short latencies with ticks, pushes and polls interleaved.
	task automatic test_short_latency_traffic();
		set_delay(16'd1);
		send_random_mix(150, 35, 35);
		set_delay(16'($urandom_range(2, 12)));
		rx_mode = RX_ALWAYS;
		send_random_mix(230, 30, 40);
		rx_mode = RX_PATTERN;
		set_delay(16'($urandom_range(2, 12)));
		send_random_mix(200, 30, 40);
	endtask

	// A long random latency holds every entry back.
	task automatic test_held_traffic();
		set_delay(16'h8000 | 16'($urandom));
		send_random_mix(110, 45, 40);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_commands();
		test_latency_hold();
		test_max_latency();
		test_zero_latency_traffic();
		test_full_queue();
		test_short_latency_traffic();
		test_held_traffic();

		wait_drained();
		if (error_count == 0)
			$display("fixed_latency_delay_queue verification clean");
		else
			$display("fixed_latency_delay_queue verification failed");
		$finish;
	end

endmodule
